// File: rtl/core/cst_pkg.sv
package cst_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // bit positions inside one command: data bits first, then crc bits
  localparam logic [5:0] FirstCrcIdx = 6'd8;
  localparam logic [5:0] LastDataIdx = 6'd7;
  localparam logic [5:0] LastIdx     = 6'd39;

  typedef enum logic [1:0] {
    CFG_SETUP_TICKS = 2'd0,
    CFG_HIGH_TICKS  = 2'd1,
    CFG_LOW_TICKS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        close;
    logic [31:0] crc;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/cst_front.sv
module cst_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  logic [7:0]      data_byte_i,
  input  logic            byte_present_i,
  input  logic            last_byte_i,
  output logic            q_push_o,
  output cst_pkg::cmd_t   q_cmd_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_next;
  logic        close;
  logic        accept;

  assign accept = push_i & ~full_i;
  // a terminator closes the frame whatever the last mark says
  assign close  = last_byte_i | ~byte_present_i;

  assign crc_next = byte_present_i ? cst_pkg::crc_byte(crc_q, data_byte_i) : crc_q;

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = close ? cst_pkg::CrcInit : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= cst_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign q_push_o        = accept;
  assign q_cmd_o.data    = data_byte_i;
  assign q_cmd_o.present = byte_present_i;
  assign q_cmd_o.close   = close;
  assign q_cmd_o.crc     = crc_next;

endmodule

// File: rtl/core/cst_queue.sv
module cst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cst_pkg::cmd_t   cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output cst_pkg::cmd_t   cmd_o,
  output logic            empty_o
);

  cst_pkg::cmd_t              mem_q [cst_pkg::QDepth];
  logic [cst_pkg::QAw-1:0]    wr_ptr_q, wr_ptr_d;
  logic [cst_pkg::QAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [cst_pkg::QAw:0]      count_q, count_d;
  logic                       do_push, do_pop;

  assign full_o  = (count_q == (cst_pkg::QAw+1)'(cst_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/core/cst_back.sv
module cst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cst_pkg::cmd_t   cmd_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            serial_bit_o,
  output logic            crc_part_o,
  output logic            run_end_o,
  output logic            frame_end_o
);

  cst_pkg::cmd_t cmd_q, cmd_d;
  logic          busy_q, busy_d;
  logic [5:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic          bit_q, bit_d;
  logic          crc_part_q, crc_part_d;
  logic          run_end_q, run_end_d;
  logic          frame_end_q, frame_end_d;

  logic          advance;
  logic          emit;
  logic [5:0]    end_idx;
  logic          last_bit;
  logic          load;
  logic [5:0]    crc_off;

  // output slot is free or being taken this cycle
  assign advance  = ~out_valid_q | pop_i;
  assign emit     = busy_q & advance;
  assign end_idx  = cmd_q.close ? cst_pkg::LastIdx : cst_pkg::LastDataIdx;
  assign last_bit = (idx_q == end_idx);
  assign crc_off  = idx_q - cst_pkg::FirstCrcIdx;
  // fetch the next command when idle or on the last bit of the current one
  assign load     = ~q_empty_i & (~busy_q | (emit & last_bit));
  assign q_pop_o  = load;

  always_comb begin
    cmd_d       = cmd_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~pop_i;
    bit_d       = bit_q;
    crc_part_d  = crc_part_q;
    run_end_d   = run_end_q;
    frame_end_d = frame_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (idx_q < cst_pkg::FirstCrcIdx) begin
        bit_d      = cmd_q.data[idx_q[2:0]];
        crc_part_d = 1'b0;
      end else begin
        bit_d      = cmd_q.crc[crc_off[4:0]];
        crc_part_d = 1'b1;
      end
      run_end_d   = last_bit;
      frame_end_d = last_bit & cmd_q.close;
      idx_d       = idx_q + 1'b1;
      if (last_bit) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      cmd_d  = cmd_i;
      busy_d = 1'b1;
      idx_d  = cmd_i.present ? '0 : cst_pkg::FirstCrcIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    bit_q       <= bit_d;
    crc_part_q  <= crc_part_d;
    run_end_q   <= run_end_d;
    frame_end_q <= frame_end_d;
  end

  assign empty_o      = ~out_valid_q;
  assign serial_bit_o = bit_q;
  assign crc_part_o   = crc_part_q;
  assign run_end_o    = run_end_q;
  assign frame_end_o  = frame_end_q;

  a_frame_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> run_end_q && crc_part_q)
    else $error("frame end without run end or crc flag");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= cst_pkg::LastIdx)
    else $error("bit index past last crc bit");

  a_terminator_crc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cmd_q.present |-> idx_q >= cst_pkg::FirstCrcIdx)
    else $error("terminator emitting data bits");

  a_open_data_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cmd_q.close |-> idx_q <= cst_pkg::LastDataIdx)
    else $error("open frame byte emitting crc bits");

  a_no_pop_when_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q)
    else $error("result dropped while stalled");

endmodule

// File: rtl/core/crc_appending_serial_transmitter.sv
// Framed serial transmitter with an appended CRC-32 (reflected, poly 0xEDB88320,
// init all ones, no final xor).
// Input queue side: push/full carry one item per transfer: a frame byte,
// a byte-present flag and a last-byte flag. A byte gives 8 result bits, LSB
// first; an item that closes the frame (last byte, or no byte at all) adds the
// 32 crc bits, low byte first, and the crc restarts at all ones.
// Result queue side: empty/pop; one serial bit per transfer with crc_part,
// run_end (last bit of the item) and frame_end (last crc bit) flags.
// Configuration: cfg_valid_i/cfg_ready_o write setup, high and low tick counts
// for the pin driver; ready is always high and result values do not depend on them.
// When the block is idle, an item's first bit passes through the command queue,
// the command register and the output register before it is on the result ports.
// Throughput: the serializer emits one bit per cycle while the output slot is free
// or being popped; a 4-entry command queue lets items be taken while earlier ones
// are still being shifted out.
// Reset clears the crc to all ones, empties the queue and the output slot.
// When the receiver stalls, the current result holds, the serializer stops,
// and full rises once the command queue fills.
module crc_appending_serial_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        serial_bit_o,
  output logic        crc_part_o,
  output logic        run_end_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cst_pkg::cmd_t push_cmd;
  cst_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;

  logic [15:0] setup_ticks_q;
  logic [15:0] high_ticks_q;
  logic [15:0] low_ticks_q;

  assign cfg_ready_o = 1'b1;

  // pin timing registers; an unknown index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_ticks_q <= 16'd100;
      high_ticks_q  <= 16'd200;
      low_ticks_q   <= 16'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        cst_pkg::CFG_SETUP_TICKS: setup_ticks_q <= cfg_data_i;
        cst_pkg::CFG_HIGH_TICKS:  high_ticks_q  <= cfg_data_i;
        cst_pkg::CFG_LOW_TICKS:   low_ticks_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  cst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  cst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .serial_bit_o (serial_bit_o),
    .crc_part_o   (crc_part_o),
    .run_end_o    (run_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// File: dv/crc_frame_checker.sv
`timescale 1ns / 100ps

module crc_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        serial_bit_i,
  input  logic        crc_part_i,
  input  logic        run_end_i,
  input  logic        frame_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fail_cnt_o,
  output int unsigned item_cnt_o,
  output int unsigned frame_cnt_o,
  output int unsigned bit_cnt_o
);

  typedef struct packed {
    logic serial_bit;
    logic crc_part;
    logic run_end;
    logic frame_end;
  } line_bit_t;

  line_bit_t   tx_bits_q[$];
  logic [31:0] frame_crc;
  logic [15:0] setup_ticks, high_ticks, low_ticks;
  int unsigned fail_cnt, item_cnt, frame_cnt, bit_cnt;

  assign fail_cnt_o  = fail_cnt;
  assign item_cnt_o  = item_cnt;
  assign frame_cnt_o = frame_cnt;
  assign bit_cnt_o   = bit_cnt;

  initial begin
    fail_cnt  = 0;
    item_cnt  = 0;
    frame_cnt = 0;
    bit_cnt   = 0;
    pending_o = 0;
  end

  // reflected crc, one data bit per step
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? cst_pkg::CrcPoly : 32'd0);
    end
    return c;
  endfunction

  task automatic serialize_item(input logic [7:0] d, input logic present, input logic last);
    line_bit_t   b;
    logic [31:0] c;
    logic        closes;
    closes = last || !present;
    if (present) begin
      frame_crc = crc32_update(frame_crc, d);
      for (int j = 0; j < 8; j++) begin
        b            = '0;
        b.serial_bit = d[j];
        b.run_end    = !closes && (j == 7);
        tx_bits_q.push_back(b);
      end
    end
    if (closes) begin
      c = frame_crc;
      for (int j = 0; j < 32; j++) begin
        b            = '0;
        b.serial_bit = c[j];
        b.crc_part   = 1'b1;
        b.run_end    = (j == 31);
        b.frame_end  = (j == 31);
        tx_bits_q.push_back(b);
      end
      frame_crc = cst_pkg::CrcInit;
      frame_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_bit_t got, want;
    if (!rst_ni) begin
      tx_bits_q.delete();
      frame_crc   = cst_pkg::CrcInit;
      setup_ticks = 16'd100;
      high_ticks  = 16'd200;
      low_ticks   = 16'd100;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          cst_pkg::CFG_SETUP_TICKS: setup_ticks = cfg_data_i;
          cst_pkg::CFG_HIGH_TICKS:  high_ticks  = cfg_data_i;
          cst_pkg::CFG_LOW_TICKS:   low_ticks   = cfg_data_i;
          default: ;  // unknown index, write dropped
        endcase
      end
      if (push && !full) begin
        item_cnt++;
        serialize_item(data_byte_i, byte_present_i, last_byte_i);
      end
      if (pop && !empty) begin
        got = {serial_bit_i, crc_part_i, run_end_i, frame_end_i};
        bit_cnt++;
        if (tx_bits_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: unexpected transfer, got bit/crc/run/frame=%b%b%b%b",
                     $realtime, got.serial_bit, got.crc_part, got.run_end, got.frame_end);
          end
        end else begin
          want = tx_bits_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: mismatch bit/crc/run/frame expected=%b%b%b%b got=%b%b%b%b",
                       $realtime, want.serial_bit, want.crc_part, want.run_end,
                       want.frame_end, got.serial_bit, got.crc_part, got.run_end,
                       got.frame_end);
            end
          end
        end
      end
      pending_o <= tx_bits_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [1:0]  CfgIdxSpare = 2'd3;

  typedef enum logic [1:0] {
    POP_STEADY,
    POP_COIN,
    POP_STALLS
  } pop_mode_e;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i    = 8'd0;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i    = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic        serial_bit_o, crc_part_o, run_end_o, frame_end_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_idx_i      = 2'd0;
  logic [15:0] cfg_data_i     = 16'd0;

  int unsigned pending, fail_cnt, item_cnt, frame_cnt, bit_cnt;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned timing_sets = 0;
  pop_mode_e   pop_mode   = POP_STEADY;

  crc_appending_serial_transmitter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .serial_bit_o   (serial_bit_o),
    .crc_part_o     (crc_part_o),
    .run_end_o      (run_end_o),
    .frame_end_o    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  crc_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .serial_bit_i   (serial_bit_o),
    .crc_part_i     (crc_part_o),
    .run_end_i      (run_end_o),
    .frame_end_i    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .fail_cnt_o     (fail_cnt),
    .item_cnt_o     (item_cnt),
    .frame_cnt_o    (frame_cnt),
    .bit_cnt_o      (bit_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d serial bits still expected", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (pop_mode)
        POP_STEADY: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        default: begin
          pop <= 1'b1;
          if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  task automatic set_timing(input logic [15:0] setup, input logic [15:0] hi,
                            input logic [15:0] lo);
    logic [15:0] vals [4];
    logic [1:0]  idx  [4];
    vals = '{setup, hi, lo, 16'($urandom)};
    idx  = '{cst_pkg::CFG_SETUP_TICKS, cst_pkg::CFG_HIGH_TICKS, cst_pkg::CFG_LOW_TICKS,
             CfgIdxSpare};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_idx_i   <= idx[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    timing_sets++;
  endtask

  // push stays high between transfers of a burst
  task automatic send_item(input logic [7:0] d, input logic present, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(5, 50)) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    push           <= 1'b1;
    data_byte_i    <= d;
    byte_present_i <= present;
    last_byte_i    <= last;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  task automatic wait_drained();
    push       <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly well-formed frames; closed by a last byte or by a bare terminator
  task automatic random_frames(input int unsigned n_target);
    int unsigned sent, len;
    logic        by_term;
    sent = 0;
    while (sent < n_target) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
      by_term = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        send_item(8'($urandom), 1'b1, !by_term && (k == len - 1));
      end
      if (by_term) begin
        send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end
      sent += len + by_term;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timing(16'd1, 16'd1, 16'd1);
    pop_mode <= POP_COIN;
    // empty frames, terminator with and without the last mark
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // single byte frames at the data extremes
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // bytes closed by the last mark
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    // bytes closed by a terminator that ignores its data
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    // ascii check string 1..9
    for (int k = 1; k <= 9; k++) begin
      send_item(8'h30 + 8'(k), 1'b1, k == 9);
    end
    wait_drained();

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    pop_mode <= POP_STEADY;
    random_frames(70);
    wait_drained();

    set_timing(16'd0, 16'd0, 16'd0);
    pop_mode <= POP_STALLS;
    random_frames(70);
    wait_drained();

    set_timing(16'($urandom), 16'($urandom), 16'($urandom));
    pop_mode <= POP_COIN;
    random_frames(70);
    wait_drained();

    set_timing(16'd100, 16'd200, 16'd100);
    pop_mode <= POP_STALLS;
    random_frames(70);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d items in %0d closed frames, %0d serial bits compared",
             item_cnt, frame_cnt, bit_cnt);
    $display("timing registers rewritten %0d times, zero and full scale included", timing_sets);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d serial bit mismatches", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
